FILE: src/hkss_pkg.sv
`timescale 1ns / 1ps
package hkss_pkg;

  // Table and key geometry.
  localparam int SESSION_SLOTS = 8;
  localparam int KEY_BYTES     = 32;
  localparam int SECRET_BYTES  = 32;
  localparam int SECRET_WORDS  = SECRET_BYTES / 8;
  localparam int KWORDS        = (KEY_BYTES + 7) / 8;
  localparam int SLOT_WORDS    = 2 * KWORDS;
  localparam int NBLK          = (KEY_BYTES + 31) / 32;
  localparam int MEM_DEPTH     = SESSION_SLOTS * SLOT_WORDS;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int PEER_W        = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;

  // Stream word widths.
  localparam int IN_W  = 80;
  localparam int OUT_W = 72;

  // Fixed HKDF strings: the extract salt (22 bytes) and the two info labels.
  localparam int SALT_BYTES = 22;
  localparam logic [8*SALT_BYTES-1:0] SALT =
    176'h4155544F5341522D5365634F432D5051432D76312E30;
  localparam int ENC_LEN  = 14;
  localparam int AUTH_LEN = 18;
  localparam logic [8*ENC_LEN-1:0]  INFO_ENC  = "Encryption-Key";
  localparam logic [8*AUTH_LEN-1:0] INFO_AUTH = "Authentication-Key";

  // Bit length of a 96-byte hashed message (pad block of extract and outer hash).
  localparam logic [15:0] LEN96_BITS = 16'd768;

  localparam logic [31:0] SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] SHA_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DERIVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NOKEY = 2'd2
  } status_t;

  // Which 64-byte block is fed to the compression unit.
  typedef enum logic [2:0] {
    BLK_IPAD   = 3'd0,
    BLK_OPAD   = 3'd1,
    BLK_SECRET = 3'd2,
    BLK_IHASH  = 3'd3,
    BLK_EXPAND = 3'd4
  } blk_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_ready;
    logic       sha_start;
    logic       sha_init;
    blk_kind_t  blk;
    logic       key_prk;
    logic       capt_ihash;
    logic       capt_prk;
    logic       capt_t;
    logic       key_wr;
    logic       set_valid;
    logic       clr_valid;
    logic       out_key;
    logic       out_resp;
    status_t    resp_status;
    logic       part;
    logic [2:0] kw;
    logic       last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic      in_valid;
    cmd_code_t code;
    logic      peer_oor;
    logic      slot_ok;
    logic      sha_done;
    logic      out_taken;
  } dp_stat_t;

endpackage

FILE: src/hkss_sha.sv
`timescale 1ns / 1ps
module hkss_sha
  import hkss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         init,
  input  logic [511:0] block,
  output logic         done,
  output logic [255:0] digest
);

  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        busy;
  logic        fin;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // One round of the compression function.
  logic [31:0] t1, t2, wnew;
  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    wnew = w[0] + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[9] +
           (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
  end

  // Sequencing: 64 rounds, then a fold into the chaining value.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Working variables, schedule window and chaining value.
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= init ? SHA_IV[i] : h[i];
        if (init) h[i] <= SHA_IV[i];
      end
      for (int i = 0; i < 16; i++) w[i] <= block[511-32*i -: 32];
    end else if (busy) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
    end else if (fin) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end
  end

  assign digest = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};

endmodule

FILE: src/hkss_dpath.sv
`timescale 1ns / 1ps
module hkss_dpath
  import hkss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             s_tvalid,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  logic                     in_acc;
  cmd_code_t                code_q;
  logic [7:0]               peer_q;
  logic [63:0]              secret_store [SECRET_WORDS];
  logic [SESSION_SLOTS-1:0] slot_valid;
  logic [255:0]             prk, ihash, t_hash, digest;
  logic [511:0]             blk_vec;
  logic                     sha_done;
  logic [ADDR_W-1:0]        mem_addr;
  logic [63:0]              key_mem [MEM_DEPTH];
  logic [63:0]              mem_rdata;
  logic [63:0]              wr_word;
  status_t                  out_status;
  logic                     out_part;
  logic [2:0]               out_kwi;
  logic [63:0]              out_word;
  logic                     out_last;
  logic                     out_taken;
  logic                     peer_oor;

  assign in_acc    = s_tvalid && cmd.in_ready;
  assign out_taken = m_tvalid && m_tready;
  assign peer_oor  = {1'b0, peer_q} >= 9'(SESSION_SLOTS);

  assign stat.in_valid  = in_acc;
  assign stat.code      = code_q;
  assign stat.peer_oor  = peer_oor;
  assign stat.slot_ok   = !peer_oor && slot_valid[peer_q[PEER_W-1:0]];
  assign stat.sha_done  = sha_done;
  assign stat.out_taken = out_taken;

  // Control state: secret words, slot valid flags, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SECRET_WORDS; i++) secret_store[i] <= '0;
      slot_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (in_acc && cmd_code_t'(s_tdata[1:0]) == CMD_WRITE)
        secret_store[s_tdata[11:10]] <= s_tdata[75:12];
      if (cmd.set_valid) slot_valid[peer_q[PEER_W-1:0]] <= 1'b1;
      if (cmd.clr_valid) slot_valid[peer_q[PEER_W-1:0]] <= 1'b0;
      if (cmd.out_key || cmd.out_resp) m_tvalid <= 1'b1;
      else if (out_taken)              m_tvalid <= 1'b0;
    end
  end

  // Latched command and hash results.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_q <= cmd_code_t'(s_tdata[1:0]);
      peer_q <= s_tdata[9:2];
    end
    if (cmd.capt_ihash) ihash  <= digest;
    if (cmd.capt_prk)   prk    <= digest;
    if (cmd.capt_t)     t_hash <= digest;
  end

  // Message block builder for every block the HMAC sequences need.
  always_comb begin
    int          off;
    int          ilen;
    int          j;
    logic [15:0] blen;
    logic [7:0]  kb;
    logic [7:0]  bt;
    off  = cmd.kw[2] ? 32 : 0;
    ilen = cmd.part ? AUTH_LEN : ENC_LEN;
    blen = 16'((64 + off + ilen + 1) * 8);
    blk_vec = '0;
    for (int i = 0; i < 64; i++) begin
      j  = i - off;
      kb = 8'h00;
      if (cmd.key_prk) begin
        if (i < 32) kb = prk[255-8*i -: 8];
      end else begin
        if (i < SALT_BYTES) kb = SALT[8*(SALT_BYTES-1-i) +: 8];
      end
      bt = 8'h00;
      case (cmd.blk)
        BLK_IPAD: bt = kb ^ 8'h36;
        BLK_OPAD: bt = kb ^ 8'h5c;
        BLK_SECRET, BLK_IHASH: begin
          if (i < 32) begin
            if (cmd.blk == BLK_SECRET) bt = secret_store[i/8][63-8*(i%8) -: 8];
            else                       bt = ihash[255-8*i -: 8];
          end else if (i == 32) bt = 8'h80;
          else if (i == 62)     bt = LEN96_BITS[15:8];
          else if (i == 63)     bt = LEN96_BITS[7:0];
        end
        BLK_EXPAND: begin
          if (i < off) bt = t_hash[255-8*i -: 8];
          else if (j < ilen) begin
            if (cmd.part) bt = INFO_AUTH[8*(AUTH_LEN-1-j) +: 8];
            else          bt = INFO_ENC[8*(ENC_LEN-1-j) +: 8];
          end
          else if (j == ilen)     bt = 8'(cmd.kw[2]) + 8'd1;
          else if (j == ilen + 1) bt = 8'h80;
          else if (i == 62)       bt = blen[15:8];
          else if (i == 63)       bt = blen[7:0];
        end
        default: bt = 8'h00;
      endcase
      blk_vec[511-8*i -: 8] = bt;
    end
  end

  hkss_sha u_sha (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.sha_start),
    .init   (cmd.sha_init),
    .block  (blk_vec),
    .done   (sha_done),
    .digest (digest)
  );

  // Key word taken from the expand output, bytes past the key length cleared.
  always_comb begin
    wr_word = t_hash[255-64*int'(cmd.kw[1:0]) -: 64];
    for (int b = 0; b < 8; b++) begin
      if (int'(cmd.kw) * 8 + b >= KEY_BYTES) wr_word[63-8*b -: 8] = 8'h00;
    end
  end

  assign mem_addr = ADDR_W'(int'(peer_q) * SLOT_WORDS + int'(cmd.part) * KWORDS +
                            int'(cmd.kw));

  // Key table memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.key_wr) key_mem[mem_addr] <= wr_word;
    mem_rdata <= key_mem[mem_addr];
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_key) begin
      out_status <= ST_OK;
      out_part   <= cmd.part;
      out_kwi    <= cmd.kw;
      out_word   <= mem_rdata;
      out_last   <= cmd.last;
    end else if (cmd.out_resp) begin
      out_status <= cmd.resp_status;
      out_part   <= 1'b0;
      out_kwi    <= '0;
      out_word   <= '0;
      out_last   <= 1'b1;
    end
  end

  assign m_tdata = {3'b000, out_word, out_kwi, out_status};
  assign m_tuser = out_part;
  assign m_tlast = out_last;

endmodule

FILE: src/hkss_ctrl.sv
`timescale 1ns / 1ps
module hkss_ctrl
  import hkss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CHECK     = 9'b000000010,
    S_HSTART    = 9'b000000100,
    S_HWAIT     = 9'b000001000,
    S_KWRITE    = 9'b000010000,
    S_EMIT_RD   = 9'b000100000,
    S_EMIT_LD   = 9'b001000000,
    S_EMIT_WAIT = 9'b010000000,
    S_RESP_WAIT = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] hstep, hstep_next;
  logic       job_exp, job_exp_next;
  logic       part, part_next;
  logic [2:0] kw, kw_next;
  logic       kw_end;
  logic       last_word;

  assign kw_end    = (4'({1'b0, kw}) == 4'(KWORDS - 1));
  assign last_word = part && kw_end;

  always_comb begin
    cmd          = '0;
    cmd.part     = part;
    cmd.kw       = kw;
    cmd.key_prk  = job_exp;
    cmd.last     = last_word;
    state_next   = state;
    hstep_next   = hstep;
    job_exp_next = job_exp;
    part_next    = part;
    kw_next      = kw;
    // Block order of one HMAC: key^ipad, message, key^opad, inner hash.
    unique case (hstep)
      2'd0: cmd.blk = BLK_IPAD;
      2'd1: cmd.blk = job_exp ? BLK_EXPAND : BLK_SECRET;
      2'd2: cmd.blk = BLK_OPAD;
      2'd3: cmd.blk = BLK_IHASH;
      default: cmd.blk = BLK_IPAD;
    endcase
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        hstep_next   = '0;
        job_exp_next = 1'b0;
        part_next    = 1'b0;
        kw_next      = '0;
        if (stat.code == CMD_WRITE) begin
          state_next = S_IDLE;
        end else if (stat.peer_oor) begin
          cmd.out_resp    = 1'b1;
          cmd.resp_status = ST_RANGE;
          state_next      = S_RESP_WAIT;
        end else begin
          unique case (stat.code)
            CMD_DERIVE: state_next = S_HSTART;
            CMD_READ: begin
              if (stat.slot_ok) begin
                state_next = S_EMIT_RD;
              end else begin
                cmd.out_resp    = 1'b1;
                cmd.resp_status = ST_NOKEY;
                state_next      = S_RESP_WAIT;
              end
            end
            default: begin
              cmd.clr_valid   = 1'b1;
              cmd.out_resp    = 1'b1;
              cmd.resp_status = ST_OK;
              state_next      = S_RESP_WAIT;
            end
          endcase
        end
      end
      S_HSTART: begin
        cmd.sha_start  = 1'b1;
        cmd.sha_init   = !hstep[0];
        cmd.capt_ihash = (hstep == 2'd2);
        state_next     = S_HWAIT;
      end
      S_HWAIT: begin
        if (stat.sha_done) begin
          if (hstep != 2'd3) begin
            hstep_next = hstep + 2'd1;
            state_next = S_HSTART;
          end else begin
            hstep_next = '0;
            if (!job_exp) begin
              cmd.capt_prk = 1'b1;
              job_exp_next = 1'b1;
              state_next   = S_HSTART;
            end else begin
              cmd.capt_t = 1'b1;
              state_next = S_KWRITE;
            end
          end
        end
      end
      S_KWRITE: begin
        cmd.key_wr = (4'({1'b0, kw}) < 4'(KWORDS));
        if (kw[1:0] == 2'd3) begin
          if (!kw[2] && NBLK > 1) begin
            kw_next    = kw + 3'd1;
            state_next = S_HSTART;
          end else if (!part) begin
            part_next  = 1'b1;
            kw_next    = '0;
            state_next = S_HSTART;
          end else begin
            cmd.set_valid = 1'b1;
            part_next     = 1'b0;
            kw_next       = '0;
            state_next    = S_EMIT_RD;
          end
        end else begin
          kw_next = kw + 3'd1;
        end
      end
      S_EMIT_RD: state_next = S_EMIT_LD;
      S_EMIT_LD: begin
        cmd.out_key = 1'b1;
        state_next  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (stat.out_taken) begin
          if (last_word) begin
            state_next = S_IDLE;
          end else begin
            if (kw_end) begin
              part_next = 1'b1;
              kw_next   = '0;
            end else begin
              kw_next = kw + 3'd1;
            end
            state_next = S_EMIT_RD;
          end
        end
      end
      S_RESP_WAIT: begin
        if (stat.out_taken) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      hstep   <= '0;
      job_exp <= 1'b0;
      part    <= 1'b0;
      kw      <= '0;
    end else begin
      state   <= state_next;
      hstep   <= hstep_next;
      job_exp <= job_exp_next;
      part    <= part_next;
      kw      <= kw_next;
    end
  end

endmodule

FILE: src/hkdf_session_key_store_core.sv
`timescale 1ns / 1ps
// Secret write: accepted in S_IDLE, next word taken after a pass through S_CHECK.
// Derive: twelve SHA-256 compressions on one round unit, four key writes after each
// expand HMAC, then the eight key words are emitted. Read: each key word passes
// S_EMIT_RD, S_EMIT_LD and S_EMIT_WAIT; errors and clear: one response word.
// Synchronous reset clears the secret words and all slot valid flags.
module hkdf_session_key_store_core
  import hkss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // command[1:0], peer_id[9:2], word_index[11:10], secret_word[75:12], zero fill
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[1:0], key_word_index[4:2], key_word[68:5], zero fill
  output logic [OUT_W-1:0] m_tdata,
  // key_part[0]
  output logic             m_tuser,
  output logic             m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign s_tready = cmd.in_ready;

  hkss_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  hkss_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: verif/tb_hkdf_session_key_store_core.sv
`timescale 1ns / 1ps
module tb_hkdf_session_key_store_core;
  import hkss_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 250;

  typedef bit [7:0] bytes_t[$];

  // One output word as the block should present it.
  typedef struct {
    status_t   status;
    bit        part;
    bit [2:0]  kw;
    bit [63:0] word;
    bit        last;
  } key_word_t;

  // Key table model: tracks the secret, the slots and the words still owed.
  class key_store_scoreboard;
    bit [63:0] secret[SECRET_WORDS];
    bit [63:0] slot_keys[SESSION_SLOTS][SLOT_WORDS];
    bit        slot_ok[SESSION_SLOTS];
    key_word_t pending[$];

    function automatic bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Plain SHA-256 over a byte string.
    function automatic bytes_t sha256(bytes_t m);
      bit [31:0] h[8];
      bit [31:0] w[64];
      bit [31:0] v[8];
      bit [31:0] t1, t2, s0, s1;
      bit [63:0] nbits;
      bytes_t dig;
      nbits = 64'(m.size()) * 8;
      for (int i = 0; i < 8; i++) h[i] = SHA_IV[i];
      m.push_back(8'h80);
      while (m.size() % 64 != 56) m.push_back(8'h00);
      for (int i = 7; i >= 0; i--) m.push_back(nbits[8*i +: 8]);
      for (int b = 0; b < m.size() / 64; b++) begin
        for (int i = 0; i < 16; i++)
          w[i] = {m[64*b+4*i], m[64*b+4*i+1], m[64*b+4*i+2], m[64*b+4*i+3]};
        for (int i = 16; i < 64; i++) begin
          s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
          s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
          w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = h[i];
        for (int i = 0; i < 64; i++) begin
          t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
               ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
          t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
               ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
          v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
          v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) h[i] += v[i];
      end
      for (int i = 0; i < 8; i++)
        for (int j = 3; j >= 0; j--) dig.push_back(h[i][8*j +: 8]);
      return dig;
    endfunction

    function automatic bytes_t hmac(bytes_t key, bytes_t msg);
      bytes_t inner, outer;
      while (key.size() < 64) key.push_back(8'h00);
      for (int i = 0; i < 64; i++) begin
        inner.push_back(key[i] ^ 8'h36);
        outer.push_back(key[i] ^ 8'h5c);
      end
      inner = {inner, msg};
      outer = {outer, sha256(inner)};
      return sha256(outer);
    endfunction

    // Label constants are stored with the first character in the top byte.
    function automatic bytes_t label_bytes(logic [255:0] s, int n);
      bytes_t b;
      for (int i = 0; i < n; i++) b.push_back(s[8*(n-1-i) +: 8]);
      return b;
    endfunction

    function automatic bytes_t expand_key(bytes_t prk, bytes_t info);
      bytes_t t, okm, msg;
      bit [7:0] ctr;
      ctr = 8'd1;
      while (okm.size() < KEY_BYTES) begin
        msg = {t, info};
        msg.push_back(ctr);
        t = hmac(prk, msg);
        for (int i = 0; i < 32 && okm.size() < KEY_BYTES; i++) okm.push_back(t[i]);
        ctr++;
      end
      while (okm.size() < 8 * KWORDS) okm.push_back(8'h00);
      return okm;
    endfunction

    function automatic void owe(status_t st, bit part, bit [2:0] kw, bit [63:0] word,
                                bit last);
      key_word_t r;
      r.status = st; r.part = part; r.kw = kw; r.word = word; r.last = last;
      pending.push_back(r);
    endfunction

    function automatic void owe_slot(int p);
      for (int k = 0; k < SLOT_WORDS; k++)
        owe(ST_OK, 1'(k / KWORDS), 3'(k % KWORDS), slot_keys[p][k], k == SLOT_WORDS - 1);
    endfunction

    // Note an accepted command and queue the words it should produce.
    function automatic void note_command(cmd_code_t cmd, bit [7:0] peer, bit [1:0] widx,
                                         bit [63:0] data);
      bytes_t sec, prk, ke, ka;
      if (cmd == CMD_WRITE) begin
        if (widx < SECRET_WORDS) secret[widx] = data;
        return;
      end
      if (peer >= SESSION_SLOTS) begin
        owe(ST_RANGE, 0, 0, 0, 1);
        return;
      end
      case (cmd)
        CMD_DERIVE: begin
          for (int i = 0; i < SECRET_WORDS; i++)
            for (int j = 7; j >= 0; j--) sec.push_back(secret[i][8*j +: 8]);
          prk = hmac(label_bytes(SALT, SALT_BYTES), sec);
          ke = expand_key(prk, label_bytes(INFO_ENC, ENC_LEN));
          ka = expand_key(prk, label_bytes(INFO_AUTH, AUTH_LEN));
          for (int i = 0; i < KWORDS; i++) begin
            slot_keys[peer][i] = {ke[8*i], ke[8*i+1], ke[8*i+2], ke[8*i+3],
                                  ke[8*i+4], ke[8*i+5], ke[8*i+6], ke[8*i+7]};
            slot_keys[peer][KWORDS+i] = {ka[8*i], ka[8*i+1], ka[8*i+2], ka[8*i+3],
                                         ka[8*i+4], ka[8*i+5], ka[8*i+6], ka[8*i+7]};
          end
          slot_ok[peer] = 1;
          owe_slot(peer);
        end
        CMD_READ: begin
          if (!slot_ok[peer]) owe(ST_NOKEY, 0, 0, 0, 1);
          else owe_slot(peer);
        end
        default: begin
          for (int k = 0; k < SLOT_WORDS; k++) slot_keys[peer][k] = 0;
          slot_ok[peer] = 0;
          owe(ST_OK, 0, 0, 0, 1);
        end
      endcase
    endfunction

    // Compare a received word with the oldest one owed; empty string means a match.
    function automatic string check_word(key_word_t got);
      key_word_t e;
      if (pending.size() == 0)
        return $sformatf("unexpected word status=%0d word=%h", got.status, got.word);
      e = pending.pop_front();
      if (got.status != e.status || got.part != e.part || got.kw != e.kw ||
          got.word != e.word || got.last != e.last)
        return $sformatf("got st=%0d part=%0d idx=%0d word=%h last=%0d, want st=%0d part=%0d idx=%0d word=%h last=%0d",
                         got.status, got.part, got.kw, got.word, got.last,
                         e.status, e.part, e.kw, e.word, e.last);
      return "";
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             m_tlast;

  key_store_scoreboard keys_sb = new();
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 0;
  int  hold_left = 0;

  hkdf_session_key_store_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Receiver: random stalls, or a long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor and idle watchdog.
  always @(posedge clk) begin
    key_word_t got;
    string msg;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[1:0]);
        got.kw = m_tdata[4:2];
        got.word = m_tdata[68:5];
        got.part = m_tuser;
        got.last = m_tlast;
        msg = keys_sb.check_word(got);
        if (msg != "") report(msg);
      end
    end
  end

  // Offer one command word and wait until it is taken; starts and ends at a falling edge.
  task automatic send_cmd(cmd_code_t cmd, bit [7:0] peer, bit [1:0] widx, bit [63:0] data);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct && gaps < 40) gaps++;
    if (gaps > 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, data, widx, peer, cmd};
    do @(posedge clk); while (!s_tready);
    keys_sb.note_command(cmd, peer, widx, data);
    @(negedge clk);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic load_secret(bit [63:0] w0, bit [63:0] w1, bit [63:0] w2, bit [63:0] w3);
    send_cmd(CMD_WRITE, 0, 2'd0, w0);
    send_cmd(CMD_WRITE, 0, 2'd1, w1);
    send_cmd(CMD_WRITE, 0, 2'd2, w2);
    send_cmd(CMD_WRITE, 0, 2'd3, w3);
  endtask

  initial begin
    int sent;
    int r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero secret, bad peers, invalid slots, extreme secret words.
    send_cmd(CMD_DERIVE, 8'd0, 2'd0, 64'd0);
    send_cmd(CMD_READ, 8'd0, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_READ, 8'd1, 2'd0, 64'd0);
    send_cmd(CMD_CLEAR, 8'd0, 2'd0, 64'd0);
    send_cmd(CMD_READ, 8'd0, 2'd0, 64'd0);
    send_cmd(CMD_DERIVE, 8'd255, 2'd0, 64'd0);
    send_cmd(CMD_READ, 8'(SESSION_SLOTS), 2'd0, 64'd0);
    send_cmd(CMD_CLEAR, 8'd200, 2'd0, 64'd0);
    send_cmd(CMD_CLEAR, 8'd3, 2'd0, 64'd0);
    load_secret('1, '1, '1, '1);
    send_cmd(CMD_DERIVE, 8'(SESSION_SLOTS - 1), 2'd0, 64'd0);
    send_cmd(CMD_READ, 8'(SESSION_SLOTS - 1), 2'd0, 64'd0);
    load_secret(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF,
                64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send_cmd(CMD_DERIVE, 8'd2, 2'd0, 64'd0);
    send_cmd(CMD_READ, 8'd2, 2'd0, 64'd0);

    // Long receiver hold-off while commands keep coming, so the block backs up.
    hold_request = 1;
    for (int i = 0; i < 6; i++) send_cmd(CMD_READ, 8'd2, 2'd0, 64'd0);

    // Random part, idling mode changing every sixty commands.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ((sent / 60) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      r = $urandom_range(99);
      if (r < 35) begin
        load_secret(rand64(), rand64(), rand64(), rand64());
        send_cmd(CMD_DERIVE, 8'($urandom_range(SESSION_SLOTS - 1)), 2'($urandom()), rand64());
        sent += 5;
      end else if (r < 60) begin
        send_cmd(CMD_READ, 8'($urandom_range(SESSION_SLOTS - 1)), 2'($urandom()), rand64());
        sent++;
      end else if (r < 72) begin
        send_cmd(CMD_CLEAR, 8'($urandom_range(SESSION_SLOTS - 1)), 2'($urandom()), rand64());
        sent++;
      end else if (r < 80) begin
        send_cmd(CMD_DERIVE, 8'($urandom_range(SESSION_SLOTS - 1)), 2'($urandom()), rand64());
        sent++;
      end else if (r < 90) begin
        send_cmd(CMD_WRITE, 8'($urandom()), 2'($urandom()), rand64());
        sent++;
      end else begin
        send_cmd(cmd_code_t'($urandom_range(3)), 8'($urandom_range(255, SESSION_SLOTS)),
                 2'($urandom()), rand64());
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then allow a short tail for stray words.
    while (keys_sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (keys_sb.pending.size() != 0) report("words still owed at the end");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: hkdf_session_key_store_core.f
src/hkss_pkg.sv
src/hkss_sha.sv
src/hkss_dpath.sv
src/hkss_ctrl.sv
src/hkdf_session_key_store_core.sv
verif/tb_hkdf_session_key_store_core.sv
